### rtl/dcfs_pkg.sv
// Package with the shared widths, microcode types and control store of the divisor-count filter.
package dcfs_pkg;

  // Field widths.
  localparam int NumberBits = 20;
  localparam int SumBits    = 48;
  localparam int TargetBits = 8;
  localparam int CountBits  = TargetBits + 1;

  // Trial divisors run up to one past the square root of the largest candidate.
  localparam int RootBits   = (NumberBits + 1) / 2 + 1;
  localparam int SqBits     = 2 * RootBits;
  localparam int BitIdxBits = $clog2(NumberBits);

  // Program counter and step addresses of the control store.
  localparam int PcBits = 3;
  localparam logic [PcBits-1:0] StepSquare = 3'd0;
  localparam logic [PcBits-1:0] StepTest   = 3'd1;
  localparam logic [PcBits-1:0] StepDiv    = 3'd2;
  localparam logic [PcBits-1:0] StepCount  = 3'd3;
  localparam logic [PcBits-1:0] StepLoop   = 3'd4;
  localparam logic [PcBits-1:0] StepSpare  = 3'd5;
  localparam logic [PcBits-1:0] StepFinish = 3'd6;
  localparam logic [PcBits-1:0] StepIdle   = 3'd7;

  // Branch conditions: a true condition jumps to the target, else the next step follows.
  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondNoRequest,
    CondSqAboveN,
    CondMoreBits,
    CondSaturated,
    CondOutBlocked
  } cond_e;

  // Datapath operations.
  typedef enum logic [2:0] {
    OpNone,
    OpLoad,
    OpSquare,
    OpInitDiv,
    OpDivStep,
    OpCount,
    OpEmit
  } op_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [PcBits-1:0] target;
  } ucode_t;

  // Control store: one control word per step.
  function automatic ucode_t ucode_rom(input logic [PcBits-1:0] pc);
    ucode_t w;
    case (pc)
      StepSquare: w = '{op: OpSquare,  cond: CondNever,      target: StepSquare};
      StepTest:   w = '{op: OpInitDiv, cond: CondSqAboveN,   target: StepFinish};
      StepDiv:    w = '{op: OpDivStep, cond: CondMoreBits,   target: StepDiv};
      StepCount:  w = '{op: OpCount,   cond: CondSaturated,  target: StepFinish};
      StepLoop:   w = '{op: OpNone,    cond: CondAlways,     target: StepSquare};
      StepSpare:  w = '{op: OpNone,    cond: CondAlways,     target: StepIdle};
      StepFinish: w = '{op: OpEmit,    cond: CondOutBlocked, target: StepFinish};
      StepIdle:   w = '{op: OpLoad,    cond: CondNoRequest,  target: StepIdle};
      default:    w = '{op: OpNone,    cond: CondAlways,     target: StepIdle};
    endcase
    return w;
  endfunction

endpackage

### rtl/divisor_count_filter_sum.sv
// The run time for candidate n is set by the bit-serial remainder unit, which
// takes one bit of n per cycle for each trial divisor.
// When the count reaches target plus one at trial divisor j, the search ends at j.
// Throughput: one request at a time; the next request is taken as soon as the result
// sits in the output register. Reset clears the target, the running sum and the sequencer;
// no clearing pass is needed.
module divisor_count_filter_sum (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dcfs_pkg::TargetBits-1:0]  cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dcfs_pkg::NumberBits-1:0]  candidate_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dcfs_pkg::NumberBits-1:0]  number_out_o,
  output logic                             is_match_o,
  output logic [dcfs_pkg::CountBits-1:0]   divisor_total_o,
  output logic [dcfs_pkg::SumBits-1:0]     running_sum_o
);

  logic [dcfs_pkg::PcBits-1:0]     pc_q, pc_d;
  logic [dcfs_pkg::TargetBits-1:0] tgt_q;
  logic [dcfs_pkg::SumBits-1:0]    sum_q, sum_d;
  logic                            out_valid_q;
  logic [dcfs_pkg::NumberBits-1:0] n_q, n_d;
  logic [dcfs_pkg::RootBits-1:0]   j_q, j_d;
  logic [dcfs_pkg::SqBits-1:0]     sq_q, sq_d;
  logic [dcfs_pkg::RootBits-1:0]   rem_q, rem_d;
  logic [dcfs_pkg::BitIdxBits-1:0] k_q, k_d;
  logic [dcfs_pkg::CountBits-1:0]  cnt_q, cnt_d;
  logic [dcfs_pkg::NumberBits-1:0] num_out_q;
  logic                            match_out_q;
  logic [dcfs_pkg::CountBits-1:0]  total_out_q;

  dcfs_pkg::ucode_t uw;
  logic             req_taken;
  logic             out_blocked;
  logic             cond_true;
  logic [dcfs_pkg::SqBits-1:0]     n_wide;
  logic [dcfs_pkg::SqBits-1:0]     j_sq_op;
  logic [dcfs_pkg::RootBits:0]     rem_sh;
  logic [dcfs_pkg::RootBits:0]     j_wide;
  logic                            divides;
  logic [dcfs_pkg::CountBits:0]    cnt_sum;
  logic [dcfs_pkg::CountBits:0]    cnt_lim;
  logic                            saturated;
  logic                            hit;

  // Current control word and handshake state.
  assign uw          = dcfs_pkg::ucode_rom(pc_q);
  assign in_ready_o  = (pc_q == dcfs_pkg::StepIdle);
  assign req_taken   = in_valid_i && in_ready_o;
  assign out_blocked = out_valid_q && !out_ready_i;

  // Datapath comparisons shared by the conditions and the operations.
  assign n_wide    = {{(dcfs_pkg::SqBits - dcfs_pkg::NumberBits){1'b0}}, n_q};
  assign j_sq_op   = {{(dcfs_pkg::SqBits - dcfs_pkg::RootBits){1'b0}}, j_q};
  assign rem_sh    = {rem_q, n_q[k_q]};
  assign j_wide    = {1'b0, j_q};
  assign divides   = (rem_q == '0);
  assign cnt_sum   = {1'b0, cnt_q} + ((sq_q == n_wide) ? (dcfs_pkg::CountBits+1)'(1)
                                                       : (dcfs_pkg::CountBits+1)'(2));
  assign cnt_lim   = {2'b00, tgt_q} + (dcfs_pkg::CountBits+1)'(1);
  assign saturated = divides && (cnt_sum >= cnt_lim);
  assign hit       = (cnt_q == {1'b0, tgt_q});

  // Branch condition select.
  always_comb begin
    case (uw.cond)
      dcfs_pkg::CondNever:      cond_true = 1'b0;
      dcfs_pkg::CondAlways:     cond_true = 1'b1;
      dcfs_pkg::CondNoRequest:  cond_true = !in_valid_i;
      dcfs_pkg::CondSqAboveN:   cond_true = (sq_q > n_wide);
      dcfs_pkg::CondMoreBits:   cond_true = (k_q != '0);
      dcfs_pkg::CondSaturated:  cond_true = saturated;
      dcfs_pkg::CondOutBlocked: cond_true = out_blocked;
      default:                  cond_true = 1'b1;
    endcase
  end

  assign pc_d = cond_true ? uw.target : pc_q + dcfs_pkg::PcBits'(1);

  // Datapath operations driven by the control word.
  always_comb begin
    n_d   = n_q;
    j_d   = j_q;
    sq_d  = sq_q;
    rem_d = rem_q;
    k_d   = k_q;
    cnt_d = cnt_q;
    sum_d = sum_q;
    case (uw.op)
      dcfs_pkg::OpLoad: begin
        if (req_taken) begin
          n_d   = candidate_i;
          j_d   = dcfs_pkg::RootBits'(1);
          cnt_d = '0;
        end
      end
      dcfs_pkg::OpSquare: begin
        sq_d = j_sq_op * j_sq_op;
      end
      dcfs_pkg::OpInitDiv: begin
        rem_d = '0;
        k_d   = dcfs_pkg::BitIdxBits'(dcfs_pkg::NumberBits - 1);
      end
      dcfs_pkg::OpDivStep: begin
        if (rem_sh >= j_wide) begin
          rem_d = dcfs_pkg::RootBits'(rem_sh - j_wide);
        end else begin
          rem_d = rem_sh[dcfs_pkg::RootBits-1:0];
        end
        k_d = k_q - dcfs_pkg::BitIdxBits'(1);
      end
      dcfs_pkg::OpCount: begin
        if (divides) begin
          cnt_d = saturated ? cnt_lim[dcfs_pkg::CountBits-1:0]
                            : cnt_sum[dcfs_pkg::CountBits-1:0];
        end
        j_d = j_q + dcfs_pkg::RootBits'(1);
      end
      dcfs_pkg::OpEmit: begin
        if (!out_blocked && hit) begin
          sum_d = sum_q + {{(dcfs_pkg::SumBits - dcfs_pkg::NumberBits){1'b0}}, n_q};
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers: sequencer, target, running sum and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= dcfs_pkg::StepIdle;
      tgt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      sum_q <= sum_d;
      if (cfg_we_i) begin
        tgt_q <= cfg_wdata_i;
      end
      if (uw.op == dcfs_pkg::OpEmit && !out_blocked) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    j_q   <= j_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    k_q   <= k_d;
    cnt_q <= cnt_d;
    if (uw.op == dcfs_pkg::OpEmit && !out_blocked) begin
      num_out_q   <= n_q;
      match_out_q <= hit;
      total_out_q <= cnt_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign number_out_o    = num_out_q;
  assign is_match_o      = match_out_q;
  assign divisor_total_o = total_out_q;
  assign running_sum_o   = sum_q;

endmodule

### rtl/dcfs_checker.sv
// Port-level checker for the divisor-count filter, bound to the top level.
module dcfs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             cfg_we_i,
  input logic [dcfs_pkg::TargetBits-1:0]  cfg_wdata_i,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [dcfs_pkg::NumberBits-1:0]  number_out_o,
  input logic                             is_match_o,
  input logic [dcfs_pkg::CountBits-1:0]   divisor_total_o,
  input logic [dcfs_pkg::SumBits-1:0]     running_sum_o
);

  logic [dcfs_pkg::TargetBits-1:0] tgt_q;
  logic [dcfs_pkg::SumBits-1:0]    last_sum_q;
  logic [dcfs_pkg::SumBits-1:0]    sum_plus;
  logic [dcfs_pkg::CountBits-1:0]  lim;

  // Shadow copies of the target and of the last delivered sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q      <= '0;
      last_sum_q <= '0;
    end else begin
      if (cfg_we_i) begin
        tgt_q <= cfg_wdata_i;
      end
      if (out_valid_o && out_ready_i) begin
        last_sum_q <= running_sum_o;
      end
    end
  end

  assign sum_plus = last_sum_q
                  + {{(dcfs_pkg::SumBits - dcfs_pkg::NumberBits){1'b0}}, number_out_o};
  assign lim      = {1'b0, tgt_q} + dcfs_pkg::CountBits'(1);

  // A taken request keeps the block busy in the following cycle.
  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while the previous one is still in work");

  // A stalled result holds its value.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(running_sum_o)
      && $stable(divisor_total_o))
    else $error("stalled result changed");

  // The match flag agrees with the count and the target, and the count never exceeds target plus one.
  a_match_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_match_o == (divisor_total_o == {1'b0, tgt_q}))
      && (divisor_total_o <= lim))
    else $error("match flag or saturated count inconsistent with target");

  // The sum moves only by the matching number.
  a_sum_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_match_o ? (running_sum_o == sum_plus)
                                : (running_sum_o == last_sum_q)))
    else $error("running sum does not follow the delivered results");

endmodule

bind divisor_count_filter_sum dcfs_checker u_dcfs_checker (.*);
